/* hw/rtl/tracker_cell_to_event_converter_top_assert.svh */
// Assertion macros for the pattern cell to event converter.
`ifndef TRACKER_CELL_TO_EVENT_CONVERTER_TOP_ASSERT_SVH
`define TRACKER_CELL_TO_EVENT_CONVERTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TCEC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TCEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tcec_pkg.sv */
// Shared types, codes and tables of the pattern cell to event converter.
`timescale 1ns / 1ps

package tcec_pkg;

  // Descending period table; a period maps to NOTE_BASE plus the number of
  // entries above it. The terminating zero entry is implied.
  localparam int PERIOD_ENTRIES = 60;
  localparam logic [11:0] PERIOD_TAB [PERIOD_ENTRIES] = '{
    12'd1712, 12'd1616, 12'd1524, 12'd1440, 12'd1356, 12'd1280,
    12'd1208, 12'd1140, 12'd1076, 12'd1016, 12'd960,  12'd912,
    12'd856,  12'd808,  12'd762,  12'd720,  12'd678,  12'd640,
    12'd604,  12'd570,  12'd538,  12'd508,  12'd480,  12'd453,
    12'd428,  12'd404,  12'd381,  12'd360,  12'd339,  12'd320,
    12'd302,  12'd285,  12'd269,  12'd254,  12'd240,  12'd226,
    12'd214,  12'd202,  12'd190,  12'd180,  12'd170,  12'd160,
    12'd151,  12'd143,  12'd135,  12'd127,  12'd120,  12'd113,
    12'd107,  12'd101,  12'd95,   12'd90,   12'd85,   12'd80,
    12'd75,   12'd71,   12'd67,   12'd63,   12'd60,   12'd56
  };

  localparam logic [6:0] NOTE_BASE   = 7'd36;
  localparam logic [6:0] NOTE_RETRIG = 7'd127;
  localparam logic [7:0] VOL_NONE    = 8'hFF;
  localparam logic [7:0] VOL_MAX     = 8'd64;
  localparam logic [7:0] TEMPO_LIMIT = 8'd32;
  localparam logic [7:0] BEND_MAX    = 8'd127;
  localparam logic [7:0] PAN_OFFSET  = 8'd192;
  localparam logic [7:0] SLIDE_UP_MIN = 8'h10;

  typedef enum logic {
    OP_CELL = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  // Output command codes
  typedef enum logic [6:0] {
    CMD_INSTR      = 7'd0,
    CMD_VOLUME_ABS = 7'd1,
    CMD_NOTE_DELAY = 7'd2,
    CMD_BENDER_TO  = 7'd3,
    CMD_TEMPO      = 7'd4,
    CMD_EXT_TEMPO  = 7'd5,
    CMD_GOTO       = 7'd6,
    CMD_BREAK      = 7'd7,
    CMD_VOLUME     = 7'd8,
    CMD_BENDER     = 7'd9,
    CMD_VIBRATO    = 7'd10,
    CMD_TONE_VOL   = 7'd11,
    CMD_VIBR_VOL   = 7'd12,
    CMD_TREMOLO    = 7'd13,
    CMD_ARPEGGIO   = 7'd14,
    CMD_OFFSET     = 7'd15,
    CMD_PAN        = 7'd16,
    CMD_RETRIG     = 7'd17,
    CMD_FINETUNE   = 7'd18,
    CMD_FINEVOL    = 7'd19,
    CMD_NOTE_CUT   = 7'd20,
    CMD_SYNC       = 7'd21
  } cmd_e;

  // Cell effect numbers
  typedef enum logic [3:0] {
    FX_ARPEGGIO   = 4'h0,
    FX_PORTA_UP   = 4'h1,
    FX_PORTA_DOWN = 4'h2,
    FX_TONE_PORTA = 4'h3,
    FX_VIBRATO    = 4'h4,
    FX_TONE_VOL   = 4'h5,
    FX_VIBR_VOL   = 4'h6,
    FX_TREMOLO    = 4'h7,
    FX_PAN        = 4'h8,
    FX_OFFSET     = 4'h9,
    FX_VOL_SLIDE  = 4'hA,
    FX_JUMP       = 4'hB,
    FX_SET_VOL    = 4'hC,
    FX_BREAK      = 4'hD,
    FX_EXTENDED   = 4'hE,
    FX_SPEED      = 4'hF
  } fx_e;

  // Extended effect sub-codes (high nibble of the parameter)
  typedef enum logic [3:0] {
    EX_FINE_UP   = 4'h1,
    EX_FINE_DOWN = 4'h2,
    EX_SYNC      = 4'h8,
    EX_RETRIG    = 4'h9,
    EX_VOL_UP    = 4'hA,
    EX_VOL_DOWN  = 4'hB,
    EX_CUT       = 4'hC,
    EX_DELAY     = 4'hD
  } ext_e;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } cell_t;

  typedef struct packed {
    logic [5:0] row;
    logic       is_note;
    logic [6:0] code;
    logic [7:0] value;
  } event_t;

  // Decoded cell: events in order from slot 0, plus how many are used
  typedef struct packed {
    event_t [2:0] ev;
    logic   [1:0] count;
  } dec_t;

  typedef struct packed {
    logic       free;
    logic [1:0] count;
  } buf_stat_t;

endpackage

/* hw/rtl/tracker_cell_to_event_converter_top.sv */
// Top level of the tracker pattern cell to event converter.
`timescale 1ns / 1ps
`include "tracker_cell_to_event_converter_top_assert.svh"

// Usage:
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// opcode 0 is a pattern cell for the next row, opcode 1 loads a default
// instrument volume. Output channel (out_valid_o / out_stall_i) carries one
// event per transfer; last_event_o marks the final event of a cell, and a
// cell with no events produces no transfer at all.
// An accepted item waits in the input register until taken, is decoded in a
// single pass and its events are visible on the output the cycle after, so
// a cell's first event passes the input register and then the result buffer.
// A cell holds the result buffer until its last event is sent, one event per
// transfer; the single output channel sets the cell rate. Volume loads never
// wait on the output. The next item is accepted while earlier events drain.
// Reset clears the row counter, the current instrument, the volume table,
// old_tempo_mode and both handshakes. While out_stall_i is high the head
// event holds; once the buffer cannot take the next cell, in_stall_o rises.
// cfg_we_i writes old_tempo_mode; write it only while the block is idle.
module tracker_cell_to_event_converter_top #(
  parameter int ROWS_PER_TRACK   = 64,
  parameter int INSTRUMENT_SLOTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] cell_byte0_i,
  input  logic [7:0] cell_byte1_i,
  input  logic [7:0] cell_byte2_i,
  input  logic [7:0] cell_byte3_i,
  input  logic [4:0] load_index_i,
  input  logic [7:0] load_volume_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] event_row_o,
  output logic       is_note_o,
  output logic [6:0] event_code_o,
  output logic [7:0] event_value_o,
  output logic       last_event_o
);

  localparam int RW = (ROWS_PER_TRACK > 1) ? $clog2(ROWS_PER_TRACK) : 1;

  logic                 tempo_q;
  logic                 in_v_q, in_v_d;
  tcec_pkg::op_e        op_q;
  tcec_pkg::cell_t      cell_q;
  logic [4:0]           ld_idx_q;
  logic [7:0]           ld_vol_q;
  logic [RW-1:0]        row_q, row_d;
  logic                 cur_v_q, cur_v_d;
  logic [4:0]           cur_q, cur_d;
  logic [8:0]           row_ext;
  logic                 accept;
  logic                 cell_go;
  logic                 load_go;
  logic                 instr_set;
  logic [4:0]           instr_idx;
  logic [6:0]           ins_vol;
  tcec_pkg::dec_t       dec;
  tcec_pkg::event_t     ev;
  tcec_pkg::buf_stat_t  buf_stat;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q <= 1'b0;
    end else if (cfg_we_i) begin
      tempo_q <= cfg_wdata_i;
    end
  end

  // input register handshake
  assign load_go    = in_v_q && (op_q == tcec_pkg::OP_LOAD);
  assign cell_go    = in_v_q && (op_q == tcec_pkg::OP_CELL) && buf_stat.free;
  assign in_stall_o = in_v_q && !(cell_go || load_go);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_v_d     = accept ? 1'b1 : ((cell_go || load_go) ? 1'b0 : in_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= tcec_pkg::op_e'(opcode_i);
      cell_q   <= {cell_byte0_i, cell_byte1_i, cell_byte2_i, cell_byte3_i};
      ld_idx_q <= load_index_i;
      ld_vol_q <= load_volume_i;
    end
  end

  // row counter and current instrument; track boundary drops the instrument
  always_comb begin
    row_d   = row_q;
    cur_v_d = cur_v_q;
    cur_d   = cur_q;
    if (cell_go) begin
      if (instr_set) begin
        cur_v_d = 1'b1;
        cur_d   = instr_idx;
      end
      if (row_q == RW'(ROWS_PER_TRACK - 1)) begin
        row_d   = '0;
        cur_v_d = 1'b0;
        cur_d   = 5'd0;
      end else begin
        row_d = row_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      cur_v_q <= 1'b0;
      cur_q   <= 5'd0;
    end else begin
      row_q   <= row_d;
      cur_v_q <= cur_v_d;
      cur_q   <= cur_d;
    end
  end

  assign row_ext = 9'(row_q);

  tcec_vol_table #(
    .INSTRUMENT_SLOTS(INSTRUMENT_SLOTS)
  ) u_vol_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (load_go),
    .wr_idx_i (ld_idx_q),
    .wr_vol_i (ld_vol_q),
    .rd_idx_i (instr_idx),
    .rd_vol_o (ins_vol)
  );

  tcec_decode u_decode (
    .cell_i      (cell_q),
    .old_tempo_i (tempo_q),
    .row_i       (row_ext[5:0]),
    .cur_valid_i (cur_v_q),
    .cur_instr_i (cur_q),
    .ins_vol_i   (ins_vol),
    .instr_set_o (instr_set),
    .instr_idx_o (instr_idx),
    .dec_o       (dec)
  );

  tcec_event_buf u_event_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (cell_go),
    .dec_i       (dec),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .ev_o        (ev),
    .last_o      (last_event_o),
    .stat_o      (buf_stat)
  );

  assign event_row_o   = ev.row;
  assign is_note_o     = ev.is_note;
  assign event_code_o  = ev.code;
  assign event_value_o = ev.value;

  // checks
  `TCEC_ASSERT_NEXT(a_cell_events_shown, clk_i, rst_ni, cell_go && (dec.count != 2'd0), out_valid_o, "decoded events not presented")
  `TCEC_ASSERT_NEXT(a_load_keeps_row, clk_i, rst_ni, load_go && !cell_go, $stable(row_q), "volume load moved the row counter")
  `TCEC_ASSERT_NEXT(a_cell_moves_row, clk_i, rst_ni, cell_go && (ROWS_PER_TRACK > 1), row_q != $past(row_q), "cell did not advance the row")

endmodule

/* hw/rtl/tcec_vol_table.sv */
// Default instrument volume table: clamped write, one read port.
`timescale 1ns / 1ps

module tcec_vol_table #(
  parameter int INSTRUMENT_SLOTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       we_i,
  input  logic [4:0] wr_idx_i,
  input  logic [7:0] wr_vol_i,
  input  logic [4:0] rd_idx_i,
  output logic [6:0] rd_vol_o
);

  localparam int IW = $clog2(INSTRUMENT_SLOTS);

  logic [6:0] vol_q [INSTRUMENT_SLOTS];
  logic       wr_ok;
  logic       rd_ok;
  logic [6:0] wr_clamped;

  // out-of-range slots are dropped on write and read as zero
  assign wr_ok = {1'b0, wr_idx_i} < 6'(INSTRUMENT_SLOTS);
  assign rd_ok = {1'b0, rd_idx_i} < 6'(INSTRUMENT_SLOTS);
  assign wr_clamped = (wr_vol_i > tcec_pkg::VOL_MAX) ? 7'(tcec_pkg::VOL_MAX) : wr_vol_i[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < INSTRUMENT_SLOTS; i++) begin
        vol_q[i] <= '0;
      end
    end else if (we_i && wr_ok) begin
      vol_q[wr_idx_i[IW-1:0]] <= wr_clamped;
    end
  end

  assign rd_vol_o = rd_ok ? vol_q[rd_idx_i[IW-1:0]] : 7'd0;

endmodule

/* hw/rtl/tcec_decode.sv */
// Cell decoder: turns one pattern cell into up to three ordered events.
`timescale 1ns / 1ps

module tcec_decode (
  input  tcec_pkg::cell_t cell_i,
  input  logic            old_tempo_i,
  input  logic [5:0]      row_i,
  input  logic            cur_valid_i,
  input  logic [4:0]      cur_instr_i,
  input  logic [6:0]      ins_vol_i,
  output logic            instr_set_o,
  output logic [4:0]      instr_idx_o,
  output tcec_pkg::dec_t  dec_o
);

  logic [11:0]       period;
  logic              has_note;
  logic [tcec_pkg::PERIOD_ENTRIES-1:0] above;
  logic [6:0]        note;
  tcec_pkg::fx_e     fx;
  logic [7:0]        data;
  logic [7:0]        volume;
  logic [4:0]        ins;
  logic [4:0]        idx;
  logic              new_instr;
  logic              note_delay;
  logic              kill_fx;
  logic [7:0]        ins_vol;
  logic [7:0]        slide;
  logic [7:0]        bend;
  logic              fx_v;
  tcec_pkg::cmd_e    fx_code;
  logic [7:0]        fx_val;
  logic [7:0]        cand_v;
  tcec_pkg::event_t  cand [8];
  logic [1:0]        n;

  function automatic tcec_pkg::event_t mk(input logic [5:0] row, input logic nt,
                                          input logic [6:0] code, input logic [7:0] val);
    tcec_pkg::event_t e;
    e.row     = row;
    e.is_note = nt;
    e.code    = code;
    e.value   = val;
    return e;
  endfunction

  // field split
  assign period  = {cell_i.b0[3:0], cell_i.b1};
  assign has_note = (period != 12'd0);
  assign fx      = tcec_pkg::fx_e'(cell_i.b2[3:0]);
  assign data    = cell_i.b3;
  assign ins     = {cell_i.b0[4], cell_i.b2[7:4]};
  assign idx     = ins - 5'd1;
  assign ins_vol = {1'b0, ins_vol_i};
  assign volume  = (fx == tcec_pkg::FX_SET_VOL) ?
                   ((data > tcec_pkg::VOL_MAX) ? tcec_pkg::VOL_MAX : data) : tcec_pkg::VOL_NONE;

  // period to note: count table entries above the period (parallel compares)
  always_comb begin
    for (int i = 0; i < tcec_pkg::PERIOD_ENTRIES; i++) begin
      above[i] = tcec_pkg::PERIOD_TAB[i] > period;
    end
  end
  assign note = tcec_pkg::NOTE_BASE + 7'($countones(above));

  assign new_instr   = !cur_valid_i || (idx != cur_instr_i);
  assign instr_set_o = (ins != 5'd0);
  assign instr_idx_o = idx;

  // note delay only counts with a note; it and tone porta suppress the effect
  assign note_delay = (fx == tcec_pkg::FX_EXTENDED) && (data[7:4] == tcec_pkg::EX_DELAY) &&
                      (data[3:0] != 4'd0) && has_note;
  assign kill_fx    = note_delay || (fx == tcec_pkg::FX_TONE_PORTA);

  assign slide = (data >= tcec_pkg::SLIDE_UP_MIN) ? {4'h0, data[7:4]} : (8'd0 - data);
  assign bend  = (data > tcec_pkg::BEND_MAX) ? tcec_pkg::BEND_MAX : data;

  // effect command
  always_comb begin
    fx_v    = 1'b0;
    fx_code = tcec_pkg::CMD_INSTR;
    fx_val  = data;
    case (fx)
      tcec_pkg::FX_SPEED: begin
        fx_v    = 1'b1;
        fx_code = (((data != 8'd0) && (data < tcec_pkg::TEMPO_LIMIT)) || old_tempo_i) ?
                  tcec_pkg::CMD_TEMPO : tcec_pkg::CMD_EXT_TEMPO;
      end
      tcec_pkg::FX_JUMP: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_GOTO;
      end
      tcec_pkg::FX_BREAK: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_BREAK;
        fx_val  = 8'd0;
      end
      tcec_pkg::FX_VOL_SLIDE: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_VOLUME;
        fx_val  = slide;
      end
      tcec_pkg::FX_PORTA_DOWN: begin
        fx_v    = (data != 8'd0);
        fx_code = tcec_pkg::CMD_BENDER;
        fx_val  = bend;
      end
      tcec_pkg::FX_PORTA_UP: begin
        fx_v    = (data != 8'd0);
        fx_code = tcec_pkg::CMD_BENDER;
        fx_val  = 8'd0 - bend;
      end
      tcec_pkg::FX_VIBRATO: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_VIBRATO;
      end
      tcec_pkg::FX_TONE_VOL: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_TONE_VOL;
        fx_val  = slide;
      end
      tcec_pkg::FX_VIBR_VOL: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_VIBR_VOL;
        fx_val  = slide;
      end
      tcec_pkg::FX_TREMOLO: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_TREMOLO;
      end
      tcec_pkg::FX_ARPEGGIO: begin
        fx_v    = (data != 8'd0);
        fx_code = tcec_pkg::CMD_ARPEGGIO;
      end
      tcec_pkg::FX_OFFSET: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_OFFSET;
      end
      tcec_pkg::FX_PAN: begin
        fx_v    = 1'b1;
        fx_code = tcec_pkg::CMD_PAN;
        fx_val  = data + tcec_pkg::PAN_OFFSET;
      end
      tcec_pkg::FX_EXTENDED: begin
        fx_val = {4'h0, data[3:0]};
        case (data[7:4])
          tcec_pkg::EX_RETRIG: begin
            fx_v    = 1'b1;
            fx_code = tcec_pkg::CMD_RETRIG;
          end
          tcec_pkg::EX_FINE_UP: begin
            fx_v    = 1'b1;
            fx_code = tcec_pkg::CMD_FINETUNE;
            fx_val  = 8'd0 - {4'h0, data[3:0]};
          end
          tcec_pkg::EX_FINE_DOWN: begin
            fx_v    = 1'b1;
            fx_code = tcec_pkg::CMD_FINETUNE;
          end
          tcec_pkg::EX_VOL_UP: begin
            fx_v    = 1'b1;
            fx_code = tcec_pkg::CMD_FINEVOL;
          end
          tcec_pkg::EX_VOL_DOWN: begin
            fx_v    = 1'b1;
            fx_code = tcec_pkg::CMD_FINEVOL;
            fx_val  = 8'd0 - {4'h0, data[3:0]};
          end
          tcec_pkg::EX_CUT: begin
            fx_v    = 1'b1;
            fx_code = tcec_pkg::CMD_NOTE_CUT;
          end
          tcec_pkg::EX_SYNC: begin
            fx_v    = 1'b1;
            fx_code = tcec_pkg::CMD_SYNC;
          end
          default: fx_v = 1'b0;
        endcase
      end
      default: fx_v = 1'b0;
    endcase
  end

  // candidate events in emission order
  always_comb begin
    cand_v[0] = instr_set_o && new_instr;
    cand[0]   = mk(row_i, 1'b0, tcec_pkg::CMD_INSTR, {3'b000, idx});
    cand_v[1] = instr_set_o && new_instr && !has_note;
    cand[1]   = mk(row_i, 1'b1, tcec_pkg::NOTE_RETRIG, tcec_pkg::VOL_NONE);
    cand_v[2] = instr_set_o && !new_instr && !has_note && (volume > tcec_pkg::VOL_MAX);
    cand[2]   = mk(row_i, 1'b0, tcec_pkg::CMD_VOLUME_ABS, ins_vol);
    cand_v[3] = note_delay;
    cand[3]   = mk(row_i, 1'b0, tcec_pkg::CMD_NOTE_DELAY, {4'h0, data[3:0]});
    cand_v[4] = (fx == tcec_pkg::FX_TONE_PORTA);
    cand[4]   = mk(row_i, 1'b0, tcec_pkg::CMD_BENDER_TO, data);
    cand_v[5] = has_note;
    cand[5]   = mk(row_i, 1'b1, note,
                   (instr_set_o && (fx != tcec_pkg::FX_SET_VOL)) ? ins_vol : volume);
    cand_v[6] = !has_note && (volume <= tcec_pkg::VOL_MAX);
    cand[6]   = mk(row_i, 1'b0, tcec_pkg::CMD_VOLUME_ABS, volume);
    cand_v[7] = fx_v && !kill_fx;
    cand[7]   = mk(row_i, 1'b0, fx_code, fx_val);
  end

  // pack valid candidates into the three slots, first come first
  always_comb begin
    n        = 2'd0;
    dec_o.ev = '0;
    for (int i = 0; i < 8; i++) begin
      if (cand_v[i] && (n != 2'd3)) begin
        dec_o.ev[n] = cand[i];
        n = n + 2'd1;
      end
    end
    dec_o.count = n;
  end

endmodule

/* hw/rtl/tcec_event_buf.sv */
// Result buffer: holds one cell's events and sends them one per transfer.
`timescale 1ns / 1ps

module tcec_event_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tcec_pkg::dec_t      dec_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output tcec_pkg::event_t    ev_o,
  output logic                last_o,
  output tcec_pkg::buf_stat_t stat_o
);

  tcec_pkg::event_t [2:0] slot_q, slot_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   pop;

  assign pop = (cnt_q != 2'd0) && !out_stall_i;

  // free when nothing remains after this cycle's transfer
  assign stat_o.free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign stat_o.count = cnt_q;

  // load a new cell or shift toward the head slot
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = dec_i.ev;
      cnt_d  = dec_i.count;
    end else if (pop) begin
      slot_d = {tcec_pkg::event_t'('0), slot_q[2:1]};
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign ev_o        = slot_q[0];
  assign last_o      = (cnt_q == 2'd1);

endmodule

/* bench/testbench.sv */
// Self-checking bench for the tracker pattern cell to event converter.
`timescale 1ns / 1ps

module testbench;

  localparam logic [7:0] VOL_CEIL = 8'd64;

  // Note periods, highest first; a period below the last entry maps one note past the last entry's note
  localparam logic [11:0] NOTE_PERIODS [60] = '{
    12'd1712, 12'd1616, 12'd1524, 12'd1440, 12'd1356, 12'd1280,
    12'd1208, 12'd1140, 12'd1076, 12'd1016, 12'd960,  12'd912,
    12'd856,  12'd808,  12'd762,  12'd720,  12'd678,  12'd640,
    12'd604,  12'd570,  12'd538,  12'd508,  12'd480,  12'd453,
    12'd428,  12'd404,  12'd381,  12'd360,  12'd339,  12'd320,
    12'd302,  12'd285,  12'd269,  12'd254,  12'd240,  12'd226,
    12'd214,  12'd202,  12'd190,  12'd180,  12'd170,  12'd160,
    12'd151,  12'd143,  12'd135,  12'd127,  12'd120,  12'd113,
    12'd107,  12'd101,  12'd95,   12'd90,   12'd85,   12'd80,
    12'd75,   12'd71,   12'd67,   12'd63,   12'd60,   12'd56
  };

  localparam tcec_pkg::ext_e EXT_CODES [8] = '{
    tcec_pkg::EX_FINE_UP, tcec_pkg::EX_FINE_DOWN, tcec_pkg::EX_SYNC, tcec_pkg::EX_RETRIG,
    tcec_pkg::EX_VOL_UP, tcec_pkg::EX_VOL_DOWN, tcec_pkg::EX_CUT, tcec_pkg::EX_DELAY
  };

  typedef struct {
    tcec_pkg::op_e op;
    logic [7:0]    b0;
    logic [7:0]    b1;
    logic [7:0]    b2;
    logic [7:0]    b3;
    logic [4:0]    load_idx;
    logic [7:0]    load_vol;
  } item_t;

  typedef struct {
    logic [5:0] row;
    logic       is_note;
    logic [6:0] code;
    logic [7:0] value;
    logic       last;
  } ev_rec_t;

  // Tracks row, instrument and volume table; queues the events each cell must produce
  class event_scoreboard;
    logic [7:0] vol_tab [32] = '{default: 8'd0};
    logic [5:0] row = '0;
    logic       owner_valid = 1'b0;
    logic [4:0] owner = '0;
    logic       tempo_mode = 1'b0;
    int         errors = 0;
    ev_rec_t    expected_q [$];
    ev_rec_t    row_evs [$];

    function void add(logic is_note, logic [6:0] code, logic [7:0] value);
      ev_rec_t e;
      if (row_evs.size() >= 3) return;
      e.row = row;
      e.is_note = is_note;
      e.code = code;
      e.value = value;
      e.last = 1'b0;
      row_evs.push_back(e);
    endfunction

    function logic [7:0] slide(logic [7:0] d);
      return (d >= 8'h10) ? (d >> 4) : 8'(0 - d);
    endfunction

    function void note_input(item_t it);
      logic [11:0]     period;
      logic [6:0]      note;
      logic            has_note;
      logic            fx_done;
      logic [7:0]      vol;
      logic [7:0]      arg;
      logic [7:0]      lo;
      logic [7:0]      bend;
      logic [4:0]      ins;
      logic [4:0]      slot;
      tcec_pkg::fx_e   fx;
      ev_rec_t         e;

      // Volume load: clamp and store, no events, row stays
      if (it.op == tcec_pkg::OP_LOAD) begin
        vol_tab[it.load_idx] = (it.load_vol > VOL_CEIL) ? VOL_CEIL : it.load_vol;
        return;
      end

      row_evs.delete();
      arg = it.b3;
      lo = {4'h0, arg[3:0]};
      bend = (arg > 8'd127) ? 8'd127 : arg;
      period = {it.b0[3:0], it.b1};
      has_note = (period != 12'd0);
      note = 7'd96;
      for (int i = 59; i >= 0; i--) begin
        if (NOTE_PERIODS[i] <= period) note = 7'(36 + i);
      end
      fx = tcec_pkg::fx_e'(it.b2[3:0]);
      fx_done = 1'b0;
      vol = 8'hFF;
      if (fx == tcec_pkg::FX_SET_VOL) vol = (arg > VOL_CEIL) ? VOL_CEIL : arg;
      ins = {it.b0[4], it.b2[7:4]};
      slot = ins - 5'd1;

      // Instrument change, or repeated instrument restoring its default volume
      if (ins != 5'd0) begin
        if (!owner_valid || slot != owner) begin
          add(1'b0, tcec_pkg::CMD_INSTR, {3'b000, slot});
          if (!has_note) add(1'b1, tcec_pkg::NOTE_RETRIG, 8'hFF);
        end else if (!has_note && vol > VOL_CEIL) begin
          add(1'b0, tcec_pkg::CMD_VOLUME_ABS, vol_tab[slot]);
        end
        owner = slot;
        owner_valid = 1'b1;
      end

      if (fx == tcec_pkg::FX_EXTENDED && arg[7:4] == tcec_pkg::EX_DELAY &&
          arg[3:0] != 4'h0 && has_note) begin
        add(1'b0, tcec_pkg::CMD_NOTE_DELAY, lo);
        fx_done = 1'b1;
      end
      if (fx == tcec_pkg::FX_TONE_PORTA) begin
        add(1'b0, tcec_pkg::CMD_BENDER_TO, arg);
        fx_done = 1'b1;
      end

      if (has_note) begin
        if (ins != 5'd0 && fx != tcec_pkg::FX_SET_VOL) vol = vol_tab[slot];
        add(1'b1, note, vol);
      end else if (vol <= VOL_CEIL) begin
        add(1'b0, tcec_pkg::CMD_VOLUME_ABS, vol);
      end

      // Effect commands
      if (!fx_done) begin
        case (fx)
          tcec_pkg::FX_SPEED: add(1'b0, ((arg != 8'd0 && arg < 8'd32) || tempo_mode) ?
                                  tcec_pkg::CMD_TEMPO : tcec_pkg::CMD_EXT_TEMPO, arg);
          tcec_pkg::FX_JUMP:       add(1'b0, tcec_pkg::CMD_GOTO, arg);
          tcec_pkg::FX_BREAK:      add(1'b0, tcec_pkg::CMD_BREAK, 8'd0);
          tcec_pkg::FX_VOL_SLIDE:  add(1'b0, tcec_pkg::CMD_VOLUME, slide(arg));
          tcec_pkg::FX_PORTA_DOWN: if (arg != 8'd0) add(1'b0, tcec_pkg::CMD_BENDER, bend);
          tcec_pkg::FX_PORTA_UP:
            if (arg != 8'd0) add(1'b0, tcec_pkg::CMD_BENDER, 8'(0 - bend));
          tcec_pkg::FX_VIBRATO:    add(1'b0, tcec_pkg::CMD_VIBRATO, arg);
          tcec_pkg::FX_TONE_VOL:   add(1'b0, tcec_pkg::CMD_TONE_VOL, slide(arg));
          tcec_pkg::FX_VIBR_VOL:   add(1'b0, tcec_pkg::CMD_VIBR_VOL, slide(arg));
          tcec_pkg::FX_TREMOLO:    add(1'b0, tcec_pkg::CMD_TREMOLO, arg);
          tcec_pkg::FX_ARPEGGIO:   if (arg != 8'd0) add(1'b0, tcec_pkg::CMD_ARPEGGIO, arg);
          tcec_pkg::FX_OFFSET:     add(1'b0, tcec_pkg::CMD_OFFSET, arg);
          tcec_pkg::FX_PAN:        add(1'b0, tcec_pkg::CMD_PAN, 8'(arg + 8'd192));
          tcec_pkg::FX_EXTENDED: begin
            case (tcec_pkg::ext_e'(arg[7:4]))
              tcec_pkg::EX_RETRIG:    add(1'b0, tcec_pkg::CMD_RETRIG, lo);
              tcec_pkg::EX_FINE_UP:   add(1'b0, tcec_pkg::CMD_FINETUNE, 8'(0 - lo));
              tcec_pkg::EX_FINE_DOWN: add(1'b0, tcec_pkg::CMD_FINETUNE, lo);
              tcec_pkg::EX_VOL_UP:    add(1'b0, tcec_pkg::CMD_FINEVOL, lo);
              tcec_pkg::EX_VOL_DOWN:  add(1'b0, tcec_pkg::CMD_FINEVOL, 8'(0 - lo));
              tcec_pkg::EX_CUT:       add(1'b0, tcec_pkg::CMD_NOTE_CUT, lo);
              tcec_pkg::EX_SYNC:      add(1'b0, tcec_pkg::CMD_SYNC, lo);
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      foreach (row_evs[k]) begin
        e = row_evs[k];
        e.last = (k == row_evs.size() - 1);
        expected_q.push_back(e);
      end

      // Track boundary drops the current instrument
      row = row + 6'd1;
      if (row == 6'd0) owner_valid = 1'b0;
    endfunction

    function void check_event(ev_rec_t got);
      ev_rec_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected event row %0d note %0b code %0d value %0d last %0b",
                 $time, got.row, got.is_note, got.code, got.value, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.row !== want.row || got.is_note !== want.is_note ||
          got.code !== want.code || got.value !== want.value ||
          got.last !== want.last) begin
        errors++;
        $display("%0t: event mismatch, expected row %0d note %0b code %0d value %0d last %0b",
                 $time, want.row, want.is_note, want.code, want.value, want.last);
        $display("%0t:                 actual   row %0d note %0b code %0d value %0d last %0b",
                 $time, got.row, got.is_note, got.code, got.value, got.last);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       opcode_i = 1'b0;
  logic [7:0] cell_byte0_i = '0;
  logic [7:0] cell_byte1_i = '0;
  logic [7:0] cell_byte2_i = '0;
  logic [7:0] cell_byte3_i = '0;
  logic [4:0] load_index_i = '0;
  logic [7:0] load_volume_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [5:0] event_row_o;
  logic       is_note_o;
  logic [6:0] event_code_o;
  logic [7:0] event_value_o;
  logic       last_event_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  event_scoreboard sb = new();

  tracker_cell_to_event_converter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .cell_byte0_i  (cell_byte0_i),
    .cell_byte1_i  (cell_byte1_i),
    .cell_byte2_i  (cell_byte2_i),
    .cell_byte3_i  (cell_byte3_i),
    .load_index_i  (load_index_i),
    .load_volume_i (load_volume_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_row_o   (event_row_o),
    .is_note_o     (is_note_o),
    .event_code_o  (event_code_o),
    .event_value_o (event_value_o),
    .last_event_o  (last_event_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Random back-pressure on the event channel
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every event transfer
  always @(posedge clk_i) begin : event_monitor
    ev_rec_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.row = event_row_o;
      got.is_note = is_note_o;
      got.code = event_code_o;
      got.value = event_value_o;
      got.last = last_event_o;
      sb.check_event(got);
    end
  end

  function automatic item_t make_cell(logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [7:0] b3);
    item_t it;
    it.op = tcec_pkg::OP_CELL;
    it.b0 = b0;
    it.b1 = b1;
    it.b2 = b2;
    it.b3 = b3;
    it.load_idx = '0;
    it.load_vol = '0;
    return it;
  endfunction

  function automatic item_t make_load(logic [4:0] idx, logic [7:0] vol);
    item_t it;
    it = make_cell(8'h00, 8'h00, 8'h00, 8'h00);
    it.op = tcec_pkg::OP_LOAD;
    it.load_idx = idx;
    it.load_vol = vol;
    return it;
  endfunction

  // Mostly cells with real periods and a few recurring instruments
  function automatic item_t random_item();
    item_t       it;
    logic [11:0] period;
    logic [4:0]  ins;
    logic [3:0]  fx;
    logic [7:0]  arg;
    int          pick;
    it.op = ($urandom_range(99) < 15) ? tcec_pkg::OP_LOAD : tcec_pkg::OP_CELL;
    it.load_idx = 5'($urandom_range(31));
    it.load_vol = ($urandom_range(2) == 0) ? 8'($urandom_range(70, 58)) :
                                             8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 25) period = '0;
    else if (pick < 60) period = NOTE_PERIODS[$urandom_range(59)];
    else if (pick < 75) period = NOTE_PERIODS[$urandom_range(59)] + 12'($urandom_range(3));
    else period = 12'($urandom_range(4095));
    pick = $urandom_range(99);
    if (pick < 35) ins = '0;
    else if (pick < 85) ins = 5'($urandom_range(4, 1));
    else ins = 5'($urandom_range(31, 1));
    fx = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 15) arg = 8'h00;
    else if (pick < 25) arg = 8'hFF;
    else arg = 8'($urandom_range(255));
    if (fx == tcec_pkg::FX_EXTENDED && $urandom_range(3) != 0) begin
      arg[7:4] = EXT_CODES[$urandom_range(7)];
    end else if (fx == tcec_pkg::FX_SPEED && $urandom_range(1) != 0) begin
      arg = 8'($urandom_range(40));
    end
    it.b0 = {3'($urandom_range(7)), ins[4], period[11:8]};
    it.b1 = period[7:0];
    it.b2 = {ins[3:0], fx};
    it.b3 = arg;
    return it;
  endfunction

  // One input transfer; valid stays up into the next item unless a gap is drawn
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= it.op;
    cell_byte0_i  <= it.b0;
    cell_byte1_i  <= it.b1;
    cell_byte2_i  <= it.b2;
    cell_byte3_i  <= it.b3;
    load_index_i  <= it.load_idx;
    load_volume_i <= it.load_vol;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  // Drain all outstanding events, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_tempo_mode(logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tempo_mode = v;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_tempo_mode(1'b0);

    // Phase 1: slow receiver
    send_idle_pct = 24;
    recv_idle_pct = 84;

    // Directed: volume loads, instrument handling and a subset of the effect families
    send_item(make_load(5'd0, 8'd255));
    send_item(make_load(5'd31, 8'd0));
    send_item(make_load(5'd1, 8'd64));
    send_item(make_cell(8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_cell(8'h06, 8'hB0, 8'h10, 8'h00));
    send_item(make_cell(8'h00, 8'h00, 8'h1C, 8'hFF));
    send_item(make_cell(8'h00, 8'h00, 8'h10, 8'h00));
    send_item(make_cell(8'hFF, 8'hFF, 8'hF0, 8'hFF));
    send_item(make_cell(8'h00, 8'h01, 8'h0E, 8'hD5));
    send_item(make_cell(8'h00, 8'h00, 8'h23, 8'h80));
    send_item(make_cell(8'h00, 8'h00, 8'h0F, 8'h00));
    send_item(make_cell(8'h00, 8'h00, 8'h0F, 8'h1F));
    send_item(make_cell(8'h00, 8'h00, 8'h0F, 8'h20));
    send_item(make_cell(8'h00, 8'h00, 8'h0B, 8'hFF));
    send_item(make_cell(8'h00, 8'h00, 8'h0D, 8'h42));
    send_item(make_cell(8'h00, 8'h00, 8'h0A, 8'h0F));
    send_item(make_cell(8'h01, 8'h00, 8'h01, 8'hFF));
    send_item(make_cell(8'h00, 8'h00, 8'h02, 8'h80));
    send_item(make_cell(8'h00, 8'h00, 8'h08, 8'h00));
    send_item(make_cell(8'h00, 8'h00, 8'h0E, 8'h1F));
    send_item(make_cell(8'h00, 8'h00, 8'h0E, 8'hBF));
    send_item(make_cell(8'h00, 8'h00, 8'h0E, 8'h05));
    repeat (40) send_item(random_item());
    settle();

    // Phase 2: slow sender, old tempo handling
    write_tempo_mode(1'b1);
    send_idle_pct = 84;
    recv_idle_pct = 24;
    repeat (40) send_item(random_item());
    settle();

    // Phase 3: back to back
    write_tempo_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) send_item(random_item());
    settle();

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
